>>> rtl/core/pol_pkg.sv
// Shared types for the positional ordered list: operation, status and cell command codes.
package pol_pkg;

  typedef enum logic [2:0] {
    OP_INSERT_AT    = 3'd0,
    OP_DELETE_AT    = 3'd1,
    OP_INSERT_FRONT = 3'd2,
    OP_INSERT_BACK  = 3'd3,
    OP_DELETE_FRONT = 3'd4,
    OP_DELETE_BACK  = 3'd5,
    OP_READ_AT      = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_e;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned PosWidth   = 8;
  localparam int unsigned OpWidth    = 3;
  localparam int unsigned StatWidth  = 2;

endpackage

>>> rtl/core/pol_cell.sv
// One list slot: holds an element and shifts from its left or right neighbor.
module pol_cell import pol_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned IDX_WIDTH  = 6,
  parameter int unsigned INDEX      = 0
) (
  input  logic                  clk_i,
  input  cell_op_e              cmd_i,
  input  logic [IDX_WIDTH-1:0]  idx_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] rd_o
);

  localparam logic [IDX_WIDTH-1:0] MyIdx = IDX_WIDTH'(INDEX);

  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (cmd_i)
      CELL_INS: begin
        // open a gap at the target slot, push the tail one place right
        if (MyIdx > idx_i) begin
          data_d = left_i;
        end else if (MyIdx == idx_i) begin
          data_d = value_i;
        end
      end
      CELL_DEL: begin
        if (MyIdx >= idx_i) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (MyIdx == idx_i) ? data_q : '0;

endmodule

>>> rtl/core/pol_ctrl.sv
// List control: element count, range checks and the command broadcast to the cells.
module pol_ctrl import pol_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic [OpWidth-1:0]                  op_i,
  input  logic [PosWidth-1:0]                 position_i,
  output cell_op_e                            cmd_o,
  output logic [$clog2(CAPACITY)-1:0]         idx_o,
  output status_e                             status_o,
  output logic [$clog2(CAPACITY+1)-1:0]       count_o,
  output logic                                rd_en_o
);

  localparam int unsigned CntWidth = $clog2(CAPACITY + 1);
  localparam int unsigned IdxWidth = $clog2(CAPACITY);
  localparam int unsigned CmpWidth = ((CntWidth > PosWidth) ? CntWidth : PosWidth) + 1;
  localparam logic [CntWidth-1:0] CapCount = CntWidth'(CAPACITY);

  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic [CmpWidth-1:0] pos_w, cnt_w;
  logic                pos_ok, pos_ok_ins, full, empty;
  logic [IdxWidth-1:0] pos_idx, cnt_idx, last_idx;
  cell_op_e            cmd;
  status_e             status;
  logic                rd_en;

  assign pos_w      = CmpWidth'(position_i);
  assign cnt_w      = CmpWidth'(cnt_q);
  assign pos_ok     = (pos_w != '0) && (pos_w <= cnt_w);
  assign pos_ok_ins = (pos_w != '0) && (pos_w <= cnt_w + CmpWidth'(1));
  assign full       = (cnt_q == CapCount);
  assign empty      = (cnt_q == '0);
  assign pos_idx    = IdxWidth'(pos_w - CmpWidth'(1));
  assign cnt_idx    = IdxWidth'(cnt_q);
  assign last_idx   = IdxWidth'(cnt_q - CntWidth'(1));

  always_comb begin
    cmd    = CELL_HOLD;
    idx_o  = pos_idx;
    status = ST_OK;
    rd_en  = 1'b0;
    case (op_e'(op_i))
      OP_INSERT_AT: begin
        if (!pos_ok_ins) begin
          status = ST_BADPOS;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          cmd = CELL_INS;
        end
      end
      OP_DELETE_AT: begin
        if (!pos_ok) begin
          status = ST_BADPOS;
        end else begin
          cmd = CELL_DEL;
        end
      end
      OP_INSERT_FRONT: begin
        idx_o = '0;
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd = CELL_INS;
        end
      end
      OP_INSERT_BACK: begin
        idx_o = cnt_idx;
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd = CELL_INS;
        end
      end
      OP_DELETE_FRONT: begin
        idx_o = '0;
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          cmd = CELL_DEL;
        end
      end
      OP_DELETE_BACK: begin
        idx_o = last_idx;
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          cmd = CELL_DEL;
        end
      end
      OP_READ_AT: begin
        if (!pos_ok) begin
          status = ST_BADPOS;
        end else begin
          rd_en = 1'b1;
        end
      end
      default: status = ST_BADPOS;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd == CELL_INS) begin
      cnt_d = cnt_q + CntWidth'(1);
    end else if (cmd == CELL_DEL) begin
      cnt_d = cnt_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept_i) begin
      cnt_q <= cnt_d;
    end
  end

  // hold the cells still unless a transaction is taken this cycle
  assign cmd_o    = accept_i ? cmd : CELL_HOLD;
  assign status_o = status;
  assign count_o  = cnt_d;
  assign rd_en_o  = rd_en;

endmodule

>>> rtl/core/positional_ordered_list.sv
// Top level of the positional ordered list: cell chain, control and result register.
// Bounded ordered list of up to CAPACITY values held in a chain of cells, slot p in
// cell p-1. Each input transaction carries one operation (insert at front, back or a
// 1-based position, delete likewise, or read at a position) and yields exactly one
// result with status, the count after the operation and the value read. The control
// broadcasts one command and every cell shifts or holds from its neighbor in that same
// cycle, so a result is in the output register in the cycle after its transaction.
// The input is ready while the output register is empty or its result is taken in the
// same cycle: with a ready receiver one operation is taken per clock, and a result that
// waits stalls the input until it is taken. Rejected operations leave the list
// unchanged. No clearing pass follows reset; the list is empty at once.
module positional_ordered_list import pol_pkg::*; #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // value [31:0], position [39:32]
  input  logic [39:0]                           s_axis_tdata_i,
  // op [2:0]
  input  logic [2:0]                            s_axis_tuser_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // count [CW-1:0], read_value [CW+31:CW], zero fill above
  output logic [(($clog2(CAPACITY+1)+32+7)/8)*8-1:0] m_axis_tdata_o,
  // status [1:0]
  output logic [1:0]                            m_axis_tuser_o
);

  localparam int unsigned CntWidth  = $clog2(CAPACITY + 1);
  localparam int unsigned IdxWidth  = $clog2(CAPACITY);
  localparam int unsigned OutBits   = CntWidth + ValueWidth;
  localparam int unsigned OutWidth  = ((OutBits + 7) / 8) * 8;

  logic                  accept;
  logic [ValueWidth-1:0] in_value;
  logic [PosWidth-1:0]   in_pos;
  logic [DATA_WIDTH-1:0] ins_value;
  logic [DATA_WIDTH-1:0] rd_any;
  logic [ValueWidth-1:0] rd_value;

  cell_op_e              cell_cmd;
  logic [IdxWidth-1:0]   cell_idx;
  status_e               res_status;
  logic [CntWidth-1:0]   res_count;
  logic                  rd_en;

  logic [DATA_WIDTH-1:0] data_w  [CAPACITY];
  logic [DATA_WIDTH-1:0] left_w  [CAPACITY];
  logic [DATA_WIDTH-1:0] right_w [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_w    [CAPACITY];

  logic                  out_valid_q;
  status_e               out_status_q;
  logic [CntWidth-1:0]   out_count_q;
  logic [ValueWidth-1:0] out_value_q;

  assign in_value        = s_axis_tdata_i[ValueWidth-1:0];
  assign in_pos          = s_axis_tdata_i[ValueWidth+PosWidth-1:ValueWidth];
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  generate
    if (DATA_WIDTH <= ValueWidth) begin : g_in_narrow
      assign ins_value = in_value[DATA_WIDTH-1:0];
      assign rd_value  = ValueWidth'(rd_any);
    end else begin : g_in_wide
      assign ins_value = DATA_WIDTH'(in_value);
      assign rd_value  = rd_any[ValueWidth-1:0];
    end
  endgenerate

  pol_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .op_i       (s_axis_tuser_i),
    .position_i (in_pos),
    .cmd_o      (cell_cmd),
    .idx_o      (cell_idx),
    .status_o   (res_status),
    .count_o    (res_count),
    .rd_en_o    (rd_en)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_w[g] = '0;
    end else begin : g_mid_l
      assign left_w[g] = data_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w[g] = '0;
    end else begin : g_mid_r
      assign right_w[g] = data_w[g+1];
    end

    pol_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_WIDTH  (IdxWidth),
      .INDEX      (g)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cell_cmd),
      .idx_i   (cell_idx),
      .value_i (ins_value),
      .left_i  (left_w[g]),
      .right_i (right_w[g]),
      .data_o  (data_w[g]),
      .rd_o    (rd_w[g])
    );
  end

  // only the addressed cell drives a nonzero word onto the read bus
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_any = rd_any | rd_w[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_status_q <= res_status;
      out_count_q  <= res_count;
      out_value_q  <= rd_en ? rd_value : '0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = OutWidth'({out_value_q, out_count_q});

endmodule

>>> bench/tb_positional_ordered_list.sv
// Self-checking testbench for the positional ordered list: stream stimulus, scoreboard, watchdog.
`timescale 1ns / 1ps

module tb_positional_ordered_list;
  import pol_pkg::*;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned CW          = $clog2(CAPACITY + 1);
  localparam int unsigned OW          = ((CW + 32 + 7) / 8) * 8;
  localparam int unsigned RandomItems = 1620;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned SettleCycles = 8;
  localparam logic [2:0]  OpUnused    = 3'd7;

  typedef struct packed {
    status_e     status;
    logic [6:0]  count;
    logic [31:0] read_value;
  } list_result_t;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          s_tvalid;
  logic          s_tready;
  logic [39:0]   s_tdata;   // value [31:0], position [39:32]
  logic [2:0]    s_tuser;   // op [2:0]
  logic          m_tvalid;
  logic          m_tready;
  logic [OW-1:0] m_tdata;   // count [CW-1:0], read_value [CW+31:CW], zero fill above
  logic [1:0]    m_tuser;   // status [1:0]

  logic [31:0]  held_q[$];       // predicted list contents, position p at index p-1
  list_result_t expected_q[$];   // results still owed by the block

  bit idle_en;
  int hold_req;
  int errors;
  int ops_sent;
  int results_seen;
  int peak_fill;
  int stall_cycles = 0;
  int status_hits[4];

  wire [CW-1:0] got_count = m_tdata[CW-1:0];
  wire [31:0]   got_value = m_tdata[CW+31:CW];
  wire [OW-CW-33:0] got_fill = m_tdata[OW-1:CW+32];

  always #2 clk_i = ~clk_i;

  positional_ordered_list #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (32)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  // Apply one operation to the predicted list and return the result it must produce.
  function automatic list_result_t apply_list_op(input logic [2:0] op, input logic [31:0] value,
                                                 input logic [7:0] pos);
    list_result_t r;
    int n;
    int p;
    n = held_q.size();
    p = pos;
    r.status = ST_OK;
    r.read_value = '0;
    case (op)
      OP_INSERT_AT: begin
        if (p < 1 || p > n + 1) r.status = ST_BADPOS;
        else if (n >= CAPACITY) r.status = ST_FULL;
        else held_q.insert(p - 1, value);
      end
      OP_DELETE_AT: begin
        if (p < 1 || p > n) r.status = ST_BADPOS;
        else held_q.delete(p - 1);
      end
      OP_INSERT_FRONT: begin
        if (n >= CAPACITY) r.status = ST_FULL;
        else held_q.push_front(value);
      end
      OP_INSERT_BACK: begin
        if (n >= CAPACITY) r.status = ST_FULL;
        else held_q.push_back(value);
      end
      OP_DELETE_FRONT: begin
        if (n == 0) r.status = ST_EMPTY;
        else void'(held_q.pop_front());
      end
      OP_DELETE_BACK: begin
        if (n == 0) r.status = ST_EMPTY;
        else void'(held_q.pop_back());
      end
      OP_READ_AT: begin
        if (p < 1 || p > n) r.status = ST_BADPOS;
        else r.read_value = held_q[p - 1];
      end
      default: r.status = ST_BADPOS;
    endcase
    r.count = 7'(held_q.size());
    return r;
  endfunction

  function automatic logic [7:0] pick_pos(input int lo, input int hi);
    return (hi < lo) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(lo, hi));
  endfunction

  // Offer one operation and hold it until the block takes it.
  task automatic send_op(input logic [2:0] op, input logic [31:0] value, input logic [7:0] pos);
    list_result_t want;
    if (idle_en && $urandom_range(99) < 17) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {pos, value};
    s_tuser  <= op;
    do @(posedge clk_i); while (!s_tready);
    want = apply_list_op(op, value, pos);
    expected_q.push_back(want);
    ops_sent++;
    status_hits[want.status]++;
    if (int'(want.count) > peak_fill) peak_fill = want.count;
  endtask

  // Mostly well-formed operations steered toward a fill goal, with some noise.
  task automatic send_random_op(input int fill_goal);
    logic [2:0] op;
    logic [7:0] pos;
    int n;
    int r;
    bit grow;
    n = held_q.size();
    r = $urandom_range(99);
    pos = pick_pos(1, n);
    if (r < 6) begin
      op  = 3'($urandom_range(0, 7));
      pos = 8'($urandom_range(0, 255));
    end else if (r < 24) begin
      op = OP_READ_AT;
    end else begin
      grow = (n < fill_goal) ? ($urandom_range(99) < 80) : ($urandom_range(99) < 20);
      case ($urandom_range(0, 2))
        0: begin
          op = grow ? OP_INSERT_AT : OP_DELETE_AT;
          if (grow) pos = pick_pos(1, n + 1);
        end
        1: op = grow ? OP_INSERT_FRONT : OP_DELETE_FRONT;
        default: op = grow ? OP_INSERT_BACK : OP_DELETE_BACK;
      endcase
    end
    send_op(op, $urandom, pos);
  endtask

  // Pause the sender until every owed result is out, then let the pipe settle.
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic test_edges();
    send_op(OP_DELETE_FRONT, 32'h0, 8'd0);
    send_op(OP_DELETE_BACK, 32'hFFFF_FFFF, 8'd255);
    send_op(OP_DELETE_AT, 32'h0, 8'd1);
    send_op(OP_READ_AT, 32'h0, 8'd0);
    send_op(OP_READ_AT, 32'h0, 8'd1);
    send_op(OP_INSERT_AT, 32'h1111_1111, 8'd0);
    send_op(OP_INSERT_AT, 32'h2222_2222, 8'd2);
    send_op(OP_INSERT_AT, 32'h0000_0000, 8'd1);
    send_op(OP_INSERT_FRONT, 32'hFFFF_FFFF, 8'd0);
    send_op(OP_INSERT_BACK, 32'h5A5A_5A5A, 8'd255);
    send_op(OP_INSERT_AT, 32'h1234_5678, 8'd4);
    send_op(OP_INSERT_AT, 32'hA5A5_A5A5, 8'd2);
    send_op(OP_READ_AT, 32'hFFFF_FFFF, 8'd1);
    send_op(OP_READ_AT, 32'h0, 8'd5);
    send_op(OP_READ_AT, 32'h0, 8'd6);
    send_op(OP_READ_AT, 32'h0, 8'd255);
    send_op(OpUnused, 32'hFFFF_FFFF, 8'd255);
    send_op(OP_DELETE_AT, 32'h0, 8'd3);
    send_op(OP_DELETE_AT, 32'h0, 8'd4);
    send_op(OP_DELETE_AT, 32'h0, 8'd0);
    send_op(OP_DELETE_FRONT, 32'h0, 8'd0);
    send_op(OP_DELETE_BACK, 32'h0, 8'd0);
    send_op(OP_READ_AT, 32'h0, 8'd1);
    send_op(OP_DELETE_AT, 32'h0, 8'd1);
  endtask

  task automatic test_full_list();
    int kind;
    while (held_q.size() < CAPACITY) begin
      kind = $urandom_range(0, 2);
      if (kind == 0) send_op(OP_INSERT_AT, $urandom, pick_pos(1, held_q.size() + 1));
      else if (kind == 1) send_op(OP_INSERT_FRONT, $urandom, 8'd0);
      else send_op(OP_INSERT_BACK, $urandom, 8'd0);
    end
    send_op(OP_INSERT_FRONT, $urandom, 8'd0);
    send_op(OP_INSERT_BACK, $urandom, 8'd0);
    send_op(OP_INSERT_AT, $urandom, 8'(CAPACITY + 1));
    send_op(OP_INSERT_AT, $urandom, 8'(CAPACITY + 2));   // position is checked before fullness
    send_op(OP_INSERT_AT, $urandom, 8'd0);
    send_op(OP_READ_AT, 32'h0, 8'(CAPACITY));
    send_op(OP_READ_AT, 32'h0, 8'(CAPACITY + 1));
    send_op(OP_DELETE_AT, 32'h0, 8'(CAPACITY + 1));
    while (held_q.size() > 0) begin
      kind = $urandom_range(0, 2);
      if (kind == 0) send_op(OP_DELETE_AT, $urandom, pick_pos(1, held_q.size()));
      else if (kind == 1) send_op(OP_DELETE_FRONT, $urandom, 8'd0);
      else send_op(OP_DELETE_BACK, $urandom, 8'd0);
    end
    send_op(OP_DELETE_BACK, 32'h0, 8'd0);
  endtask

  // Stall the result side long enough that the block must back up its input.
  task automatic test_backpressure();
    idle_en = 1'b0;
    hold_req = 300;
    repeat (24) send_random_op(CAPACITY / 2);
    idle_en = 1'b1;
  endtask

  task automatic test_random_mix();
    int fill_goal;
    fill_goal = 0;
    for (int i = 0; i < RandomItems; i++) begin
      if (i % 150 == 0) fill_goal = $urandom_range(0, CAPACITY);
      idle_en = !(i >= 700 && i < 1000);
      send_random_op(fill_goal);
    end
    idle_en = 1'b1;
  endtask

  initial begin : receiver
    m_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        m_tready <= 1'b0;
        repeat (hold_req) @(posedge clk_i);
        hold_req = 0;
      end else begin
        m_tready <= !idle_en || ($urandom_range(99) >= 17);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    list_result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing owed: status %0d count %0d value %h",
                 $time, m_tuser, got_count, got_value);
        errors++;
      end else begin
        want = expected_q.pop_front();
        results_seen++;
        if (m_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
          errors++;
        end
        if (got_count !== CW'(want.count)) begin
          $display("%0t: count expected %0d actual %0d", $time, want.count, got_count);
          errors++;
        end
        if (got_value !== want.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time, want.read_value, got_value);
          errors++;
        end
        if (got_fill !== '0) begin
          $display("%0t: fill bits expected 0 actual %h", $time, got_fill);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("%0t: no transaction for %0d cycles, %0d results owed",
               $time, stall_cycles, expected_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    rst_ni   <= 1'b0;
    idle_en = 1'b1;
    hold_req = 0;
    errors = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edges();
    wait_drain();
    test_full_list();
    wait_drain();
    test_backpressure();
    wait_drain();
    test_random_mix();
    wait_drain();

    if (expected_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_q.size());
      errors++;
    end
    $display("Run covered %0d list operations and %0d checked results, peak fill %0d of %0d",
             ops_sent, results_seen, peak_fill, CAPACITY);
    $display("Outcomes: %0d ok, %0d bad position, %0d empty, %0d full",
             status_hits[ST_OK], status_hits[ST_BADPOS], status_hits[ST_EMPTY],
             status_hits[ST_FULL]);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
